FILE: hdl/bmhpq_pkg.sv
package bmhpq_pkg;

  localparam int Depth      = 1024;
  localparam int AddrBits   = 10;
  localparam int CountBits  = 11;
  localparam int ObjBits    = 16;
  localparam int PrioBits   = 31;

  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [ObjBits-1:0]   obj_t;
  typedef logic [PrioBits-1:0]  prio_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CHANGE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,   // dispatch; for insert, read parent of hole
    S_INS_CMP,  // compare parent, move or place
    S_REM_RD,   // root and last entry in A/B; last entry to root
    S_REM_LD,   // sift-up reached root: place moving pair there
    S_DN_RD,    // read both children, or place when none
    S_DN_CMP,   // pick child, move or place
    S_CH_RD,    // read search slot, or end search as not found
    S_CH_CMP,   // compare object
    S_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    load_req;    // capture request and moving pair
    logic    rd_a;        // read port A at address
    addr_t   addr_a;
    logic    rd_b;        // read port B at address
    addr_t   addr_b;
    logic    wr;          // write entry
    addr_t   wr_addr;
    logic    wr_mov;      // write moving pair, else write read-data A/B selection
    logic    wr_sel_b;
    logic    mov_from_a;  // load moving pair from read data A
    logic    mov_from_b;  // load moving pair from read data B
    logic    prio_new;    // replace moving priority with request priority
    logic    pos_ld;
    count_t  pos_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_ld;      // capture removed object or old priority
    logic    res_rem;
    logic    done;
    status_e status;
  } cmd_t;

  typedef struct packed {
    prio_t mov_prio;
    prio_t prio_a;
    prio_t prio_b;
    obj_t  obj_a;
    obj_t  req_obj;
    prio_t req_prio;
    req_e  req_type;
    count_t pos;
    count_t count;
    count_t cap;
  } stat_t;

endpackage

FILE: hdl/binary_min_heap_priority_queue_core.sv
// Binary min-heap priority queue with up to 1024 (object, priority) entries.
// A request is a word on req_type_i, object_id_i and priority_req_i, taken
// on a clock edge where start is high and busy is low. Kinds: insert,
// remove minimum, change priority of an object; none gives only a result.
// Exactly one result word follows each request, shown for one cycle with
// result_valid_o high; the receiver cannot stall it. The result carries a
// status, the removed object or old priority, and count, empty and full.
// capacity_we_i / capacity_wdata_i write the capacity; the user must do so
// only while the block is idle, since the block itself does not enforce it.
// An insert sifts up from the new last position; a remove moves the last
// entry to the root and sifts it down; a change searches positions in order
// and sifts the found entry up or down. The next request is taken at the
// edge that takes the result, so one request is in flight at a time.
// Reset empties the queue and sets capacity to 1024; the memory is not
// cleared, since only positions below the count are ever used.
module binary_min_heap_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        capacity_we_i,
  input  logic [10:0] capacity_wdata_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] object_id_i,
  input  logic [30:0] priority_req_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] removed_object_o,
  output logic [30:0] old_priority_o,
  output logic [10:0] count_o,
  output logic        is_empty_o,
  output logic        is_full_o
);

  bmhpq_pkg::cmd_t  cmd;
  bmhpq_pkg::stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bmhpq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_type_i),
    .object_id_i      (object_id_i),
    .priority_req_i   (priority_req_i),
    .capacity_we_i    (capacity_we_i),
    .capacity_wdata_i (capacity_wdata_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .removed_object_o (removed_object_o),
    .old_priority_o   (old_priority_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

endmodule

FILE: hdl/bmhpq_datapath.sv
module bmhpq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           req_type_i,
  input  logic [15:0]          object_id_i,
  input  logic [30:0]          priority_req_i,
  input  logic                 capacity_we_i,
  input  logic [10:0]          capacity_wdata_i,
  input  bmhpq_pkg::cmd_t      cmd_i,
  output bmhpq_pkg::stat_t     stat_o,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [15:0]          removed_object_o,
  output logic [30:0]          old_priority_o,
  output logic [10:0]          count_o,
  output logic                 is_empty_o,
  output logic                 is_full_o
);

  bmhpq_pkg::obj_t   obj_mem [bmhpq_pkg::Depth];
  bmhpq_pkg::prio_t  prio_mem [bmhpq_pkg::Depth];

  bmhpq_pkg::obj_t   obj_a_q, obj_b_q, mov_obj_q, req_obj_q;
  bmhpq_pkg::prio_t  prio_a_q, prio_b_q, mov_prio_q, req_prio_q;
  bmhpq_pkg::req_e   req_type_q;
  bmhpq_pkg::count_t pos_q, count_q, cap_q, lim;
  logic              valid_q;
  logic [1:0]        status_q;
  bmhpq_pkg::obj_t   rem_q;
  bmhpq_pkg::prio_t  oldp_q;
  bmhpq_pkg::obj_t   wr_obj;
  bmhpq_pkg::prio_t  wr_prio;

  assign lim = (cap_q > bmhpq_pkg::count_t'(bmhpq_pkg::Depth))
             ? bmhpq_pkg::count_t'(bmhpq_pkg::Depth) : cap_q;

  always_comb begin
    if (cmd_i.wr_mov) begin
      wr_obj  = mov_obj_q;
      wr_prio = mov_prio_q;
    end else if (cmd_i.wr_sel_b) begin
      wr_obj  = obj_b_q;
      wr_prio = prio_b_q;
    end else begin
      wr_obj  = obj_a_q;
      wr_prio = prio_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      obj_mem[cmd_i.wr_addr]  <= wr_obj;
      prio_mem[cmd_i.wr_addr] <= wr_prio;
    end
    if (cmd_i.rd_a) begin
      obj_a_q  <= obj_mem[cmd_i.addr_a];
      prio_a_q <= prio_mem[cmd_i.addr_a];
    end
    if (cmd_i.rd_b) begin
      obj_b_q  <= obj_mem[cmd_i.addr_b];
      prio_b_q <= prio_mem[cmd_i.addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= bmhpq_pkg::req_e'(req_type_i);
      req_obj_q  <= object_id_i;
      req_prio_q <= priority_req_i;
      mov_obj_q  <= object_id_i;
      mov_prio_q <= priority_req_i;
    end else if (cmd_i.mov_from_a) begin
      mov_obj_q  <= obj_a_q;
      mov_prio_q <= cmd_i.prio_new ? req_prio_q : prio_a_q;
    end else if (cmd_i.mov_from_b) begin
      mov_obj_q  <= obj_b_q;
      mov_prio_q <= prio_b_q;
    end
    if (cmd_i.pos_ld) begin
      pos_q <= cmd_i.pos_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cap_q    <= bmhpq_pkg::count_t'(bmhpq_pkg::Depth);
      valid_q  <= 1'b0;
      status_q <= bmhpq_pkg::ST_OK;
      rem_q    <= '0;
      oldp_q   <= '0;
    end else begin
      if (capacity_we_i) begin
        cap_q <= capacity_wdata_i;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.load_req) begin
        rem_q  <= '0;
        oldp_q <= '0;
      end else if (cmd_i.res_ld) begin
        if (cmd_i.res_rem) begin
          rem_q <= obj_a_q;
        end else begin
          oldp_q <= prio_a_q;
        end
      end
      valid_q <= cmd_i.done;
      if (cmd_i.done) begin
        status_q <= cmd_i.status;
      end
    end
  end

  assign stat_o = '{mov_prio: mov_prio_q, prio_a: prio_a_q, prio_b: prio_b_q,
                    obj_a: obj_a_q, req_obj: req_obj_q, req_prio: req_prio_q,
                    req_type: req_type_q, pos: pos_q, count: count_q, cap: lim};

  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign removed_object_o = rem_q;
  assign old_priority_o   = oldp_q;
  assign count_o          = count_q;
  assign is_empty_o       = (count_q == '0);
  assign is_full_o        = (count_q >= lim);

endmodule

FILE: hdl/bmhpq_ctrl.sv
module bmhpq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bmhpq_pkg::stat_t stat_i,
  output bmhpq_pkg::cmd_t  cmd_o
);

  bmhpq_pkg::state_e state_q, state_d;
  bmhpq_pkg::status_e st_q, st_d;
  bmhpq_pkg::count_t  pos, cnt, c, up;
  logic               pick_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhpq_pkg::S_IDLE;
      st_q    <= bmhpq_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign pos = stat_i.pos;
  assign cnt = stat_i.count;
  assign up  = pos >> 1;
  assign c   = pos << 1;
  // Right child wins only when strictly smaller; left child at c, right at c+1.
  assign pick_b = (c < cnt) && (stat_i.prio_a > stat_i.prio_b);

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.status = st_q;
    busy    = (state_q != bmhpq_pkg::S_IDLE);
    unique case (state_q)
      bmhpq_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          st_d = bmhpq_pkg::ST_OK;
          // Dispatch is done on the captured request in the next state.
          state_d = bmhpq_pkg::S_INS_RD;
          cmd_o.pos_ld  = 1'b1;
          cmd_o.pos_val = cnt + 1'b1;
        end
      end
      bmhpq_pkg::S_INS_RD: begin
        // First cycle after capture: dispatch on request kind.
        unique case (stat_i.req_type)
          bmhpq_pkg::REQ_INSERT: begin
            if (cnt >= stat_i.cap) begin
              st_d = bmhpq_pkg::ST_FULL;
              state_d = bmhpq_pkg::S_DONE;
            end else begin
              cmd_o.cnt_inc = 1'b1;
              if (pos > 1) begin
                cmd_o.rd_a   = 1'b1;
                cmd_o.addr_a = bmhpq_pkg::addr_t'(up - 1'b1);
                state_d = bmhpq_pkg::S_INS_CMP;
              end else begin
                cmd_o.wr      = 1'b1;
                cmd_o.wr_mov  = 1'b1;
                cmd_o.wr_addr = '0;
                state_d = bmhpq_pkg::S_DONE;
              end
            end
          end
          bmhpq_pkg::REQ_REMOVE: begin
            if (cnt == '0) begin
              st_d = bmhpq_pkg::ST_EMPTY;
              state_d = bmhpq_pkg::S_DONE;
            end else begin
              cmd_o.rd_a   = 1'b1;
              cmd_o.addr_a = '0;
              cmd_o.rd_b   = 1'b1;
              cmd_o.addr_b = bmhpq_pkg::addr_t'(cnt - 1'b1);
              cmd_o.cnt_dec = 1'b1;
              cmd_o.pos_ld  = 1'b1;
              cmd_o.pos_val = bmhpq_pkg::count_t'(1);
              state_d = bmhpq_pkg::S_REM_RD;
            end
          end
          bmhpq_pkg::REQ_CHANGE: begin
            cmd_o.pos_ld  = 1'b1;
            cmd_o.pos_val = bmhpq_pkg::count_t'(1);
            state_d = bmhpq_pkg::S_CH_RD;
          end
          default: state_d = bmhpq_pkg::S_DONE;
        endcase
      end
      bmhpq_pkg::S_INS_CMP: begin
        // Hole at pos, parent data in A.
        if (stat_i.prio_a >= stat_i.mov_prio) begin
          cmd_o.wr      = 1'b1;
          cmd_o.wr_addr = bmhpq_pkg::addr_t'(pos - 1'b1);
          cmd_o.pos_ld  = 1'b1;
          cmd_o.pos_val = up;
          if (up > 1) begin
            cmd_o.rd_a   = 1'b1;
            cmd_o.addr_a = bmhpq_pkg::addr_t'((up >> 1) - 1'b1);
          end else begin
            state_d = bmhpq_pkg::S_REM_LD; // reused: place moving at pos
          end
        end else begin
          cmd_o.wr      = 1'b1;
          cmd_o.wr_mov  = 1'b1;
          cmd_o.wr_addr = bmhpq_pkg::addr_t'(pos - 1'b1);
          state_d = bmhpq_pkg::S_DONE;
        end
      end
      bmhpq_pkg::S_REM_LD: begin
        // Sift-up reached the root.
        cmd_o.wr      = 1'b1;
        cmd_o.wr_mov  = 1'b1;
        cmd_o.wr_addr = '0;
        state_d = bmhpq_pkg::S_DONE;
      end
      bmhpq_pkg::S_REM_RD: begin
        // A holds root, B holds last; the last entry becomes the moving pair.
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_rem = 1'b1;
        cmd_o.mov_from_b = 1'b1;
        cmd_o.wr      = 1'b1;
        cmd_o.wr_sel_b = 1'b1;
        cmd_o.wr_addr = '0;
        state_d = bmhpq_pkg::S_DN_RD;
      end
      bmhpq_pkg::S_DN_RD: begin
        if (pos <= (cnt >> 1)) begin
          cmd_o.rd_a   = 1'b1;
          cmd_o.addr_a = bmhpq_pkg::addr_t'(c - 1'b1);
          cmd_o.rd_b   = 1'b1;
          cmd_o.addr_b = bmhpq_pkg::addr_t'(c);
          state_d = bmhpq_pkg::S_DN_CMP;
        end else begin
          cmd_o.wr      = 1'b1;
          cmd_o.wr_mov  = 1'b1;
          cmd_o.wr_addr = bmhpq_pkg::addr_t'(pos - 1'b1);
          state_d = bmhpq_pkg::S_DONE;
        end
      end
      bmhpq_pkg::S_DN_CMP: begin
        if (stat_i.mov_prio <= (pick_b ? stat_i.prio_b : stat_i.prio_a)) begin
          cmd_o.wr      = 1'b1;
          cmd_o.wr_mov  = 1'b1;
          cmd_o.wr_addr = bmhpq_pkg::addr_t'(pos - 1'b1);
          state_d = bmhpq_pkg::S_DONE;
        end else begin
          cmd_o.wr       = 1'b1;
          cmd_o.wr_sel_b = pick_b;
          cmd_o.wr_addr  = bmhpq_pkg::addr_t'(pos - 1'b1);
          cmd_o.pos_ld   = 1'b1;
          cmd_o.pos_val  = pick_b ? c + 1'b1 : c;
          state_d = bmhpq_pkg::S_DN_RD;
        end
      end
      bmhpq_pkg::S_CH_RD: begin
        if (pos > cnt) begin
          st_d = bmhpq_pkg::ST_NOTFOUND;
          state_d = bmhpq_pkg::S_DONE;
        end else begin
          cmd_o.rd_a   = 1'b1;
          cmd_o.addr_a = bmhpq_pkg::addr_t'(pos - 1'b1);
          state_d = bmhpq_pkg::S_CH_CMP;
        end
      end
      bmhpq_pkg::S_CH_CMP: begin
        if (stat_i.obj_a == stat_i.req_obj) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.mov_from_a = 1'b1;
          cmd_o.prio_new   = 1'b1;
          if (stat_i.req_prio < stat_i.prio_a) begin
            // Sift up from pos: hole at pos.
            if (pos > 1) begin
              cmd_o.rd_a   = 1'b1;
              cmd_o.addr_a = bmhpq_pkg::addr_t'(up - 1'b1);
              state_d = bmhpq_pkg::S_INS_CMP;
            end else begin
              state_d = bmhpq_pkg::S_REM_LD;
            end
          end else begin
            // Sift down (or rewrite in place when equal).
            state_d = bmhpq_pkg::S_DN_RD;
          end
        end else begin
          cmd_o.pos_ld  = 1'b1;
          cmd_o.pos_val = pos + 1'b1;
          state_d = bmhpq_pkg::S_CH_RD;
        end
      end
      bmhpq_pkg::S_DONE: begin
        cmd_o.done = 1'b1;
        state_d = bmhpq_pkg::S_IDLE;
      end
      default: state_d = bmhpq_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: test/tb_top.sv
module tb_top;

  typedef struct {
    bmhpq_pkg::status_e st;
    bmhpq_pkg::obj_t    rem_obj;
    bmhpq_pkg::prio_t   old_prio;
    bmhpq_pkg::count_t  cnt;
    logic               empty;
    logic               full;
  } heap_word_t;

  // Predicts the queue and checks each result word against the oldest
  // expectation.
  class heap_scoreboard;
    bmhpq_pkg::obj_t  objs[bmhpq_pkg::Depth];
    bmhpq_pkg::prio_t prios[bmhpq_pkg::Depth];
    int         n;
    int         cap;
    heap_word_t pending[$];
    int         errors;
    int         words_checked;
    int         status_seen[4];

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function void clear();
      n = 0;
      cap = bmhpq_pkg::Depth;
      pending.delete();
    endfunction

    function void set_cap(logic [10:0] v);
      cap = (v > bmhpq_pkg::Depth) ? bmhpq_pkg::Depth : int'(v);
    endfunction

    function void rise(int p);
      bmhpq_pkg::prio_t pr;
      bmhpq_pkg::obj_t ob;
      pr = prios[p-1];
      ob = objs[p-1];
      while (p > 1 && prios[(p>>1)-1] >= pr) begin
        prios[p-1] = prios[(p>>1)-1];
        objs[p-1] = objs[(p>>1)-1];
        p = p >> 1;
      end
      prios[p-1] = pr;
      objs[p-1] = ob;
    endfunction

    function void sink(int p);
      bmhpq_pkg::prio_t pr;
      bmhpq_pkg::obj_t ob;
      int c;
      pr = prios[p-1];
      ob = objs[p-1];
      while (p <= (n >> 1)) begin
        c = p << 1;
        if (c < n && prios[c-1] > prios[c]) c++;
        if (pr <= prios[c-1]) break;
        prios[p-1] = prios[c-1];
        objs[p-1] = objs[c-1];
        p = c;
      end
      prios[p-1] = pr;
      objs[p-1] = ob;
    endfunction

    function void note_request(bmhpq_pkg::req_e k, bmhpq_pkg::obj_t ob,
                               bmhpq_pkg::prio_t pr);
      heap_word_t w;
      int hit;
      w.st = bmhpq_pkg::ST_OK;
      w.rem_obj = '0;
      w.old_prio = '0;
      case (k)
        bmhpq_pkg::REQ_INSERT: begin
          if (n >= cap) w.st = bmhpq_pkg::ST_FULL;
          else begin
            n++;
            objs[n-1] = ob;
            prios[n-1] = pr;
            rise(n);
          end
        end
        bmhpq_pkg::REQ_REMOVE: begin
          if (n == 0) w.st = bmhpq_pkg::ST_EMPTY;
          else begin
            w.rem_obj = objs[0];
            objs[0] = objs[n-1];
            prios[0] = prios[n-1];
            n--;
            if (n > 0) sink(1);
          end
        end
        bmhpq_pkg::REQ_CHANGE: begin
          hit = 0;
          for (int i = 1; i <= n; i++) begin
            if (objs[i-1] == ob) begin
              hit = i;
              break;
            end
          end
          if (hit == 0) w.st = bmhpq_pkg::ST_NOTFOUND;
          else begin
            w.old_prio = prios[hit-1];
            prios[hit-1] = pr;
            if (pr < w.old_prio) rise(hit);
            else if (pr > w.old_prio) sink(hit);
          end
        end
        default: ;
      endcase
      w.cnt = bmhpq_pkg::count_t'(n);
      w.empty = (n == 0);
      w.full = (n >= cap);
      pending.push_back(w);
    endfunction

    task check_result(logic [1:0] st, bmhpq_pkg::obj_t ro, bmhpq_pkg::prio_t op,
                      bmhpq_pkg::count_t c, logic e, logic f);
      heap_word_t w;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      w = pending.pop_front();
      words_checked++;
      status_seen[st]++;
      if (st !== w.st)
        report($sformatf("status %0d, expected %0d", st, w.st));
      if (ro !== w.rem_obj)
        report($sformatf("removed object %0h, expected %0h", ro, w.rem_obj));
      if (op !== w.old_prio)
        report($sformatf("old priority %0h, expected %0h", op, w.old_prio));
      if (c !== w.cnt)
        report($sformatf("count %0d, expected %0d", c, w.cnt));
      if (e !== w.empty)
        report($sformatf("empty %b, expected %b", e, w.empty));
      if (f !== w.full)
        report($sformatf("full %b, expected %b", f, w.full));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        capacity_we_i = 1'b0;
  logic [10:0] capacity_wdata_i = '0;
  logic [1:0]  req_type_i = '0;
  logic [15:0] object_id_i = '0;
  logic [30:0] priority_req_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [15:0] removed_object_o;
  logic [30:0] old_priority_o;
  logic [10:0] count_o;
  logic        is_empty_o;
  logic        is_full_o;

  heap_scoreboard sb = new();
  int cycles = 0;
  int gap_pct = 0;
  int requests = 0;
  localparam int CycleLimit = 10_000_000;

  binary_min_heap_priority_queue_core uut (
    .clk_i, .rst_ni, .start, .busy, .capacity_we_i, .capacity_wdata_i,
    .req_type_i, .object_id_i, .priority_req_i, .result_valid_o, .status_o,
    .removed_object_o, .old_priority_o, .count_o, .is_empty_o, .is_full_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o)
      sb.check_result(status_o, removed_object_o, old_priority_o, count_o,
                      is_empty_o, is_full_o);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one request word, holding start until the block takes it.
  // Returns at the accepting edge; whatever runs next drives start at the
  // next falling edge.
  task automatic send(bmhpq_pkg::req_e k, bmhpq_pkg::obj_t ob,
                      bmhpq_pkg::prio_t pr);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= k;
    object_id_i <= ob;
    priority_req_i <= pr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(k, ob, pr);
    requests++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [10:0] v);
    drain();
    capacity_we_i <= 1'b1;
    capacity_wdata_i <= v;
    @(negedge clk_i);
    capacity_we_i <= 1'b0;
    sb.set_cap(v);
  endtask

  function automatic bmhpq_pkg::prio_t rand_prio();
    case ($urandom_range(3))
      0: return bmhpq_pkg::prio_t'($urandom_range(15));
      1: return '1;
      default: return bmhpq_pkg::prio_t'($urandom);
    endcase
  endfunction

  // Mostly a small object pool so changes hit; sometimes any value.
  function automatic bmhpq_pkg::obj_t rand_obj();
    if ($urandom_range(3) == 0) return bmhpq_pkg::obj_t'($urandom);
    return bmhpq_pkg::obj_t'($urandom_range(40));
  endfunction

  task automatic random_phase(int items, int gap, int ins_w);
    int r;
    gap_pct = gap;
    repeat (items) begin
      r = $urandom_range(99);
      if (r < ins_w)
        send(bmhpq_pkg::REQ_INSERT, rand_obj(), rand_prio());
      else if (r < ins_w + 30)
        send(bmhpq_pkg::REQ_REMOVE, bmhpq_pkg::obj_t'($urandom),
             bmhpq_pkg::prio_t'($urandom));
      else if (r < 97)
        send(bmhpq_pkg::REQ_CHANGE, rand_obj(), rand_prio());
      else
        send(bmhpq_pkg::REQ_NONE, bmhpq_pkg::obj_t'($urandom),
             bmhpq_pkg::prio_t'($urandom));
    end
  endtask

  initial begin
    sb.clear();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty remove, extremes, equal priorities, absent change.
    send(bmhpq_pkg::REQ_REMOVE, '0, '0);
    send(bmhpq_pkg::REQ_CHANGE, 16'h1234, '0);
    send(bmhpq_pkg::REQ_INSERT, 16'hFFFF, '1);
    send(bmhpq_pkg::REQ_INSERT, 16'h0000, '0);
    send(bmhpq_pkg::REQ_INSERT, 16'h5555, 31'h2AAAAAAA);
    send(bmhpq_pkg::REQ_INSERT, 16'hAAAA, 31'h55555555);
    send(bmhpq_pkg::REQ_INSERT, 16'h0007, 31'd5);
    send(bmhpq_pkg::REQ_INSERT, 16'h0008, 31'd5);
    send(bmhpq_pkg::REQ_CHANGE, 16'hFFFF, 31'd1);
    send(bmhpq_pkg::REQ_CHANGE, 16'h0000, '1);
    send(bmhpq_pkg::REQ_CHANGE, 16'h0007, 31'd5);
    send(bmhpq_pkg::REQ_CHANGE, 16'hBEEF, 31'd3);
    send(bmhpq_pkg::REQ_NONE, 16'hFFFF, '1);
    repeat (7) send(bmhpq_pkg::REQ_REMOVE, '0, '0);
    write_capacity(11'd2);
    repeat (3) send(bmhpq_pkg::REQ_INSERT, 16'h0011, 31'd9);
    write_capacity(11'd1);
    send(bmhpq_pkg::REQ_INSERT, 16'h0012, 31'd1);
    send(bmhpq_pkg::REQ_REMOVE, '0, '0);
    write_capacity(11'd0);
    send(bmhpq_pkg::REQ_INSERT, 16'h0013, 31'd1);
    send(bmhpq_pkg::REQ_REMOVE, '0, '0);
    send(bmhpq_pkg::REQ_REMOVE, '0, '0);
    write_capacity(11'h7FF);

    random_phase(250, 0, 55);
    write_capacity(11'd1024);
    random_phase(250, 73, 50);
    write_capacity(11'd8);
    random_phase(250, 31, 60);
    drain();
    write_capacity(11'd1);
    random_phase(100, 0, 50);
    write_capacity(11'd0);
    random_phase(30, 73, 50);
    write_capacity(11'd1024);
    random_phase(150, 0, 80);

    drain();
    $display("Sent %0d request words, checked %0d results (ok %0d, full %0d,",
             requests, sb.words_checked, sb.status_seen[0], sb.status_seen[1]);
    $display("  empty %0d, not found %0d) over capacities 0 to 2047.",
             sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: binary_min_heap_priority_queue_core.f
hdl/bmhpq_pkg.sv
hdl/bmhpq_datapath.sv
hdl/bmhpq_ctrl.sv
hdl/binary_min_heap_priority_queue_core.sv
test/tb_top.sv
